// ===== src/midpoint_circle_rasterizer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mcr_pkg.sv =====
// Package: types and constants of the midpoint circle rasterizer.
`default_nettype none
package mcr_pkg;

  localparam int unsigned CoordW   = 7;
  localparam int unsigned RadiusW  = 4;
  localparam int unsigned PointW   = 8;
  localparam int unsigned DecW     = 8;
  localparam int unsigned SubW     = 3;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  localparam logic signed [DecW-1:0] DecInit     = 8'sd3;
  localparam logic [DecW-1:0]        DecStepDown = 8'd10;
  localparam logic [DecW-1:0]        DecStepKeep = 8'd6;
  localparam logic [SubW-1:0]        SubLast     = 3'd7;

  typedef struct packed {
    logic load;
    logic adv;
  } mcr_cmd_t;

  typedef struct packed {
    logic last_pt;
  } mcr_sts_t;

endpackage
`default_nettype wire

// ===== src/midpoint_circle_rasterizer.sv =====
// Top level: midpoint circle rasterizer, stream in (circle) and stream out (points).
// One input beat (center, radius; radius saturates to MAX_RADIUS) yields 8 points per
// octant step, 8 for radius 0 and up to 64 for radius 10, with tlast on the final point.
// The point sequencer produces one point per cycle while the output is taken; a circle is
// loaded and then walked point by point, and the next
// circle is accepted as soon as the final point sits in the output register.
`default_nettype none
module midpoint_circle_rasterizer #(
  parameter int unsigned PANEL_COLS = 16,
  parameter int unsigned PANEL_ROWS = 32,
  parameter int unsigned MAX_RADIUS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [6:0] center_x, [13:7] center_y, [17:14] radius, [23:18] zero
  input  wire logic [mcr_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] point_x, [15:8] point_y
  output logic [mcr_pkg::OutDataW-1:0]         m_axis_tdata,
  // [0] on_panel
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  mcr_pkg::mcr_cmd_t cmd;
  mcr_pkg::mcr_sts_t sts;
  logic signed [mcr_pkg::PointW-1:0] point_x, point_y;

  mcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcr_datapath #(
    .PANEL_COLS (PANEL_COLS),
    .PANEL_ROWS (PANEL_ROWS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .center_x_i ($signed(s_axis_tdata[6:0])),
    .center_y_i ($signed(s_axis_tdata[13:7])),
    .radius_i   (s_axis_tdata[17:14]),
    .point_x_o  (point_x),
    .point_y_o  (point_y),
    .on_panel_o (m_axis_tuser),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {point_y, point_x};

endmodule
`default_nettype wire

// ===== src/mcr_ctrl.sv =====
// Controller: input acceptance, point sequencing and output register valid.
`default_nettype none
module mcr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire mcr_pkg::mcr_sts_t sts_i,
  output mcr_pkg::mcr_cmd_t    cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic ovld_q, ovld_d;

  always_comb begin
    state_d   = state_q;
    ovld_d    = ovld_q;
    cmd_o     = '0;
    unique case (state_q)
      StIdle: begin
        if (ovld_q && out_ready_i) ovld_d = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.adv = 1'b1;
          ovld_d    = 1'b1;
          if (sts_i.last_pt) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/mcr_datapath.sv =====
// Datapath: octant walk registers, decision update and point output register.
`default_nettype none
module mcr_datapath #(
  parameter int unsigned PANEL_COLS = 16,
  parameter int unsigned PANEL_ROWS = 32,
  parameter int unsigned MAX_RADIUS = 10
) (
  input  wire logic                               clk_i,
  input  wire mcr_pkg::mcr_cmd_t                  cmd_i,
  output mcr_pkg::mcr_sts_t                       sts_o,
  input  wire logic signed [mcr_pkg::CoordW-1:0]  center_x_i,
  input  wire logic signed [mcr_pkg::CoordW-1:0]  center_y_i,
  input  wire logic [mcr_pkg::RadiusW-1:0]        radius_i,
  output logic signed [mcr_pkg::PointW-1:0]       point_x_o,
  output logic signed [mcr_pkg::PointW-1:0]       point_y_o,
  output logic                                    on_panel_o,
  output logic                                    last_o
);

  localparam logic [mcr_pkg::RadiusW-1:0] RadMax  = mcr_pkg::RadiusW'(MAX_RADIUS);
  localparam logic [mcr_pkg::PointW:0]    ColsLim = (mcr_pkg::PointW+1)'(PANEL_COLS);
  localparam logic [mcr_pkg::PointW:0]    RowsLim = (mcr_pkg::PointW+1)'(PANEL_ROWS);

  logic signed [mcr_pkg::CoordW-1:0] cx_q, cy_q;
  logic [mcr_pkg::RadiusW-1:0]       a_q, b_q, a_d, b_d;
  logic signed [mcr_pkg::DecW-1:0]   d_q, d_d;
  logic [mcr_pkg::SubW-1:0]          sub_q;
  logic signed [mcr_pkg::PointW-1:0] px_q, py_q;
  logic                              on_q, last_q;

  logic [mcr_pkg::RadiusW-1:0]       r_sat, off_h, off_v;
  logic [mcr_pkg::PointW-1:0]        ext_h, ext_v, px_c, py_c;
  logic [mcr_pkg::DecW-1:0]          diff, d_init;
  logic                              d_pos, last_c, on_c;

  assign r_sat  = (radius_i > RadMax) ? RadMax : radius_i;
  assign d_init = mcr_pkg::DecInit - {3'b000, r_sat, 1'b0};

  // sub-point order: bit2 swaps offsets, bit1 negates y, bit0 negates x
  assign off_h = sub_q[2] ? b_q : a_q;
  assign off_v = sub_q[2] ? a_q : b_q;
  assign ext_h = {4'b0000, off_h};
  assign ext_v = {4'b0000, off_v};
  assign px_c  = sub_q[0] ? ({cx_q[6], cx_q} - ext_h) : ({cx_q[6], cx_q} + ext_h);
  assign py_c  = sub_q[1] ? ({cy_q[6], cy_q} - ext_v) : ({cy_q[6], cy_q} + ext_v);
  assign on_c  = !px_c[7] && ({1'b0, px_c} < ColsLim) &&
                 !py_c[7] && ({1'b0, py_c} < RowsLim);

  assign d_pos = (d_q > 8'sd0);
  assign diff  = {4'b0000, a_q} - {4'b0000, b_q};

  always_comb begin
    a_d = a_q + 4'd1;
    if (d_pos) begin
      d_d = d_q + $signed({diff[5:0], 2'b00} + mcr_pkg::DecStepDown);
      b_d = b_q - 4'd1;
    end else begin
      d_d = d_q + $signed({2'b00, a_q, 2'b00} + mcr_pkg::DecStepKeep);
      b_d = b_q;
    end
  end

  // final step when the next a would pass the next b
  assign last_c = (sub_q == mcr_pkg::SubLast) &&
                  (d_pos ? ({1'b0, a_q} + 5'd1 >= {1'b0, b_q}) : (a_q >= b_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      a_q   <= '0;
      b_q   <= r_sat;
      d_q   <= $signed(d_init);
      sub_q <= '0;
    end else if (cmd_i.adv) begin
      px_q   <= $signed(px_c);
      py_q   <= $signed(py_c);
      on_q   <= on_c;
      last_q <= last_c;
      sub_q  <= sub_q + 3'd1;
      if (sub_q == mcr_pkg::SubLast) begin
        a_q <= a_d;
        b_q <= b_d;
        d_q <= d_d;
      end
    end
  end

  assign sts_o.last_pt = last_c;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign on_panel_o    = on_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

// ===== src/mcr_checker.sv =====
// Port-level checker for the midpoint circle rasterizer, bound to the top level.
`default_nettype none
`include "midpoint_circle_rasterizer_defines.svh"
module mcr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [mcr_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                         m_axis_tuser,
  input wire logic                         m_axis_tlast
);

  `MCR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "beat dropped")
  `MCR_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "in busy")
  `MCR_ASSERT_NOW(a_no_in_mid, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "in mid-circle")
  `MCR_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "beat changed")

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (.*);
`default_nettype wire
